[rtl/led_pattern_sequencer_assert.svh]
// assertion macros shared by the sequencer rtl
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led pattern sequencer check failed");

// next-cycle implication, checked outside reset
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led pattern sequencer check failed");

`endif

[rtl/lps_pkg.sv]
package lps_pkg;

  // default configuration of the block
  localparam int CHANNELS_DEF = 1;
  localparam int DEPTH_DEF    = 64;

  // field widths
  localparam int MS_W  = 32;
  localparam int TPS_W = 20;
  localparam int CNT_W = 42;
  localparam int SIDX_W = 6;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // duration codes and limits
  localparam logic [MS_W-1:0]  FREEZE_MS = 32'hFFFF_FFFF;
  localparam logic [MS_W-1:0]  LOOP_MS   = 32'd0;
  localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // x / 1000 is done as (x >> 3) / 125 with a rounded-up reciprocal
  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic [31:0] RECIP_Q  = 32'd549755814; // 2^36 / 125, 29-bit dividend
  localparam logic [31:0] RECIP_R  = 32'd137438954; // 2^34 / 125, 27-bit dividend

  // main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_TICK,
    ST_NEXT,
    ST_WRAP,
    ST_RD,
    ST_RDW,
    ST_CONV,
    ST_DONE
  } state_t;

  // converter states
  typedef enum logic [2:0] {
    CV_IDLE,
    CV_QUOT,
    CV_BACK,
    CV_REM,
    CV_RXT,
    CV_FRAC,
    CV_WHOLE,
    CV_SUM
  } conv_state_t;

  // request into the duration converter
  typedef struct packed {
    logic            start;
    logic [MS_W-1:0] ms;
  } conv_req_t;

  // response from the duration converter
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] ticks;
  } conv_rsp_t;

endpackage

[rtl/lps_ram.sv]
module lps_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lps_conv.sv]
module lps_conv (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lps_pkg::conv_req_t      req,
  input  logic [lps_pkg::TPS_W-1:0] tps,
  output lps_pkg::conv_rsp_t      rsp
);

  import lps_pkg::*;

  conv_state_t       state_r, state_nxt;
  logic [MS_W-1:0]   ms_r;
  logic [TPS_W-1:0]  tps_r;
  logic [63:0]       p_r;
  logic [22:0]       qm_r;
  logic [9:0]        rm_r;
  logic [20:0]       frac_r;
  logic [CNT_W-1:0]  ticks_r, ticks_nxt;
  logic              done_r, done_nxt;

  logic [31:0]       mul_a, mul_b;
  logic              mul_en;
  logic [63:0]       prod;
  logic [31:0]       rem_full;
  logic [CNT_W+1:0]  sum;

  // the one shared multiplier
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  assign rem_full = ms_r - p_r[31:0];
  assign sum      = {1'b0, p_r[CNT_W:0]} + (CNT_W+2)'(frac_r);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (req.start && state_r == CV_IDLE) begin
      ms_r  <= req.ms;
      tps_r <= tps;
    end
    if (mul_en) begin
      p_r <= prod;
    end
    if (state_r == CV_BACK) begin
      qm_r <= p_r[58:36];
    end
    if (state_r == CV_REM) begin
      rm_r <= rem_full[9:0];
    end
    if (state_r == CV_WHOLE) begin
      frac_r <= p_r[54:34];
    end
    if (state_r == CV_SUM) begin
      ticks_r <= ticks_nxt;
    end
  end

  // ticks = (ms / 1000) * tps + ((ms % 1000) * tps) / 1000
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    done_nxt  = 1'b0;
    ticks_nxt = ticks_r;
    unique case (state_r)
      CV_IDLE: begin
        if (req.start) begin
          state_nxt = CV_QUOT;
        end
      end
      CV_QUOT: begin
        mul_a     = {3'd0, ms_r[MS_W-1:3]};
        mul_b     = RECIP_Q;
        mul_en    = 1'b1;
        state_nxt = CV_BACK;
      end
      CV_BACK: begin
        mul_a     = {9'd0, p_r[58:36]};
        mul_b     = MS_PER_S;
        mul_en    = 1'b1;
        state_nxt = CV_REM;
      end
      CV_REM: begin
        state_nxt = CV_RXT;
      end
      CV_RXT: begin
        mul_a     = {22'd0, rm_r};
        mul_b     = {12'd0, tps_r};
        mul_en    = 1'b1;
        state_nxt = CV_FRAC;
      end
      CV_FRAC: begin
        mul_a     = {5'd0, p_r[29:3]};
        mul_b     = RECIP_R;
        mul_en    = 1'b1;
        state_nxt = CV_WHOLE;
      end
      CV_WHOLE: begin
        mul_a     = {9'd0, qm_r};
        mul_b     = {12'd0, tps_r};
        mul_en    = 1'b1;
        state_nxt = CV_SUM;
      end
      CV_SUM: begin
        // saturate, and never less than one tick
        if (sum > (CNT_W+2)'(CNT_MAX)) begin
          ticks_nxt = CNT_MAX;
        end else if (sum == '0) begin
          ticks_nxt = CNT_W'(1);
        end else begin
          ticks_nxt = sum[CNT_W-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = CV_IDLE;
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.ticks = ticks_r;

endmodule

[rtl/led_pattern_sequencer.sv]
// led pattern sequencer
// in_* stream: one word per item. tuser gives the kind: tick, load entry or
// start pattern. tdata carries channel, entry index, entry level, entry
// duration in ms and start index. out_* stream: one word per item with the
// led level and active bit of every channel, taken after the item is applied.
// cfg_wr_en / cfg_wr_data write ticks_per_second; write only while idle.
// An item occupies the block until its word is produced; in_tready is low
// meanwhile. A load goes straight to its word. A start reduces the start
// index modulo the memory depth, reads the entry and converts its duration.
// A tick visits every channel in turn: where the counter does not expire it
// counts down; where it expires the next entry is read and the channel
// freezes, moves to that entry or, on a loop, restarts the pattern.
// Item time is set by the single pattern memory read port and the duration
// converter, which runs five passes of one shared 32x32 multiplier.
// The finished word waits in an output register: the next item is accepted
// while it waits, but its word is only written once the register is free.
// Reset (rst_n low at a clock edge) clears all channels to off and inactive
// and sets ticks_per_second to 1000; the pattern memory keeps its contents.
module led_pattern_sequencer #(
  parameter int CHANNELS      = lps_pkg::CHANNELS_DEF,
  parameter int PATTERN_DEPTH = lps_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // channel[2:0], entry_index[8:3], entry_level[9], entry_duration_ms[41:10],
  // start_index[47:42]
  input  logic [47:0]               in_tdata,
  // mode[1:0]
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // led_levels[7:0], active_mask[15:8]
  output logic [15:0]               out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [lps_pkg::TPS_W-1:0] cfg_wr_data
);

  import lps_pkg::*;

  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW = (AW > SIDX_W) ? AW : SIDX_W;
  localparam logic [MW:0] DEPTH_M = (MW+1)'(PATTERN_DEPTH);
  localparam logic [AW:0] DEPTH_A = (AW+1)'(PATTERN_DEPTH);
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);
  localparam logic [7:0] CH_MASK = 8'((1 << CHANNELS) - 1);

  // input word fields
  logic [2:0]        in_channel;
  logic [5:0]        in_entry_index;
  logic              in_entry_level;
  logic [MS_W-1:0]   in_entry_duration_ms;
  logic [SIDX_W-1:0] in_start_index;
  logic              in_acc;

  assign in_channel           = in_tdata[2:0];
  assign in_entry_index       = in_tdata[8:3];
  assign in_entry_level       = in_tdata[9];
  assign in_entry_duration_ms = in_tdata[41:10];
  assign in_start_index       = in_tdata[47:42];
  assign in_acc               = in_tvalid && in_tready;

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     ch_r, ch_nxt;
  logic [MW-1:0]     addr_r, addr_nxt;
  logic              begin_r, begin_nxt;
  logic [1:0]        mode_r;
  logic              st_ok_r;
  logic [SIDX_W-1:0] sidx_r;
  logic [TPS_W-1:0]  tps_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [15:0]       out_tdata_r;

  // per-channel state
  logic [CNT_W-1:0]  cnt_r [CHANNELS];
  logic [AW-1:0]     pos_r [CHANNELS];
  logic [SIDX_W-1:0] pst_r [CHANNELS];
  logic [CHANNELS-1:0] act_r;
  logic [CHANNELS-1:0] lvl_r;

  // channel write controls
  logic              cnt_we, lvl_we, lvl_wd, act_we, act_wd, pos_we, pst_we;
  logic [CNT_W-1:0]  cnt_wd, cnt_dec;
  logic [AW-1:0]     pos_wd;
  logic [AW:0]       a_inc;
  logic              out_load;

  // pattern memory
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [32:0]       mem_rdata;
  logic              rd_level;
  logic [MS_W-1:0]   rd_dur;

  conv_req_t         conv_req;
  conv_rsp_t         conv_rsp;

  assign mem_we    = in_acc && (in_tuser == MODE_LOAD) &&
                     ({26'd0, in_entry_index} < 32'(PATTERN_DEPTH));
  assign mem_waddr = AW'(in_entry_index);
  assign rd_level  = mem_rdata[32];
  assign rd_dur    = mem_rdata[31:0];

  lps_ram #(
    .WIDTH (33),
    .DEPTH (PATTERN_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_entry_level, in_entry_duration_ms}),
    .raddr (addr_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  lps_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .tps   (tps_r),
    .rsp   (conv_rsp)
  );

  assign cnt_dec = cnt_r[ch_r] - CNT_W'(1);
  assign a_inc   = {1'b0, addr_r[AW-1:0]} + (AW+1)'(1);
  assign pos_wd  = (a_inc == DEPTH_A) ? '0 : a_inc[AW-1:0];

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ch_r         <= '0;
      begin_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      tps_r        <= TPS_RESET;
    end else begin
      state_r      <= state_nxt;
      ch_r         <= ch_nxt;
      begin_r      <= begin_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
    end
  end

  // item payload and result word
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (in_acc) begin
      mode_r  <= in_tuser;
      st_ok_r <= ({1'b0, in_channel} < 4'(CHANNELS));
      sidx_r  <= in_start_index;
    end
    if (out_load) begin
      out_tdata_r <= {8'(act_r), 8'(lvl_r)};
    end
  end

  // channel state updates, always at the current channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= '0;
        pos_r[i] <= '0;
        pst_r[i] <= '0;
      end
      act_r <= '0;
      lvl_r <= '0;
    end else begin
      if (cnt_we) begin
        cnt_r[ch_r] <= cnt_wd;
      end
      if (pos_we) begin
        pos_r[ch_r] <= pos_wd;
      end
      if (pst_we) begin
        pst_r[ch_r] <= sidx_r;
      end
      if (act_we) begin
        act_r[ch_r] <= act_wd;
      end
      if (lvl_we) begin
        lvl_r[ch_r] <= lvl_wd;
      end
    end
  end

  // sequencer: next state and controls
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    addr_nxt       = addr_r;
    begin_nxt      = begin_r;
    in_tready      = 1'b0;
    cnt_we         = 1'b0;
    cnt_wd         = cnt_dec;
    lvl_we         = 1'b0;
    lvl_wd         = rd_level;
    act_we         = 1'b0;
    act_wd         = 1'b0;
    pos_we         = 1'b0;
    pst_we         = 1'b0;
    conv_req.start = 1'b0;
    conv_req.ms    = rd_dur;
    out_load       = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            MODE_TICK: begin
              ch_nxt    = '0;
              state_nxt = ST_TICK;
            end
            MODE_START: begin
              ch_nxt    = CW'(in_channel);
              state_nxt = ST_START;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_START: begin
        // a start repeating the running pattern is dropped
        if (st_ok_r && !(act_r[ch_r] && pst_r[ch_r] == sidx_r)) begin
          pst_we    = 1'b1;
          act_we    = 1'b1;
          act_wd    = 1'b1;
          addr_nxt  = MW'(sidx_r);
          begin_nxt = 1'b1;
          state_nxt = ST_WRAP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TICK: begin
        if (cnt_r[ch_r] == '0) begin
          state_nxt = ST_NEXT;
        end else begin
          cnt_we = 1'b1;
          if (cnt_dec != '0) begin
            state_nxt = ST_NEXT;
          end else if (!act_r[ch_r]) begin
            lvl_we    = 1'b1;
            lvl_wd    = 1'b0;
            state_nxt = ST_NEXT;
          end else begin
            addr_nxt  = MW'(pos_r[ch_r]);
            begin_nxt = 1'b0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_NEXT: begin
        if (ch_r == LAST_CH) begin
          state_nxt = ST_DONE;
        end else begin
          ch_nxt    = ch_r + CW'(1);
          state_nxt = ST_TICK;
        end
      end
      ST_WRAP: begin
        // start index modulo the memory depth, one subtract a cycle
        if ({1'b0, addr_r} >= DEPTH_M) begin
          addr_nxt = addr_r - DEPTH_M[MW-1:0];
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        pos_we = 1'b1;
        if (begin_r) begin
          lvl_we         = 1'b1;
          conv_req.start = 1'b1;
          state_nxt      = ST_CONV;
        end else if (rd_dur == FREEZE_MS) begin
          lvl_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wd    = '0;
          act_we    = 1'b1;
          act_wd    = 1'b0;
          state_nxt = ST_NEXT;
        end else if (rd_dur == LOOP_MS) begin
          addr_nxt  = MW'(pst_r[ch_r]);
          begin_nxt = 1'b1;
          state_nxt = ST_WRAP;
        end else begin
          lvl_we         = 1'b1;
          conv_req.start = 1'b1;
          state_nxt      = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_rsp.done) begin
          cnt_we    = 1'b1;
          cnt_wd    = conv_rsp.ticks;
          state_nxt = (mode_r == MODE_TICK) ? ST_NEXT : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `include "led_pattern_sequencer_assert.svh"

  `LPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready)
  `LPS_ASSERT_NOW(a_conv_done_in_conv, clk, rst_n, conv_rsp.done, state_r == ST_CONV)
  `LPS_ASSERT_NOW(a_active_has_count, clk, rst_n, (state_r == ST_IDLE) && act_r[0], cnt_r[0] != '0)
  `LPS_ASSERT_NOW(a_unused_bits_zero, clk, rst_n, out_tvalid_r, ((out_tdata_r[15:8] | out_tdata_r[7:0]) & ~CH_MASK) == 8'd0)

endmodule
